### src/udp_client_connection_fsm_top_macros.svh
// Assertion macros shared by the connection state machine RTL.
`ifndef UDP_CLIENT_CONNECTION_FSM_TOP_MACROS_SVH
`define UDP_CLIENT_CONNECTION_FSM_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UCF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ucfsm assertion failed");
`define UCF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ucfsm assertion failed");
`else
`define UCF_ASSERT(label, clk, rst, prop)
`define UCF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### src/ucfsm_pkg.sv
// Types, codes and constants of the client connection state machine.
`timescale 1ns / 1ps
`default_nettype none
package ucfsm_pkg;

   localparam int DISCONNECT_BURST_DEFAULT = 10;
   localparam int MAX_SERVERS_DEFAULT      = 32;
   localparam int RES_CAP                  = 11;
   localparam int COUNT_W                  = 4;
   localparam int QUEUE_DEPTH              = 2;
   localparam int MS_PER_S                 = 1000;
   localparam int ATTEMPT_BACKOFF_MS       = 1000;
   localparam int CFG_MS_W                 = 26;

   localparam logic signed [32:0] TIME_RESET_MS = -33'sd1000000;

   localparam logic [CFG_MS_W-1:0] TIMEOUT_MS_RESET  = 26'd0;
   localparam logic [CFG_MS_W-1:0] LIFETIME_MS_RESET = 26'd30000;
   localparam logic [5:0]          SERVER_COUNT_RESET = 6'd1;
   localparam logic [15:0]         RESEND_MS_RESET   = 16'd100;

   localparam logic [3:0] ST_EXPIRED      = 4'd0;
   localparam logic [3:0] ST_INVALID      = 4'd1;
   localparam logic [3:0] ST_TIMED_OUT    = 4'd2;
   localparam logic [3:0] ST_REQ_TIMEOUT  = 4'd3;
   localparam logic [3:0] ST_RESP_TIMEOUT = 4'd4;
   localparam logic [3:0] ST_DENIED       = 4'd5;
   localparam logic [3:0] ST_DISCONNECTED = 4'd6;
   localparam logic [3:0] ST_REQUESTING   = 4'd7;
   localparam logic [3:0] ST_RESPONDING   = 4'd8;
   localparam logic [3:0] ST_CONNECTED    = 4'd9;

   typedef enum logic [9:0] {
      CS_EXPIRED      = 10'b00_0000_0001,
      CS_INVALID      = 10'b00_0000_0010,
      CS_TIMED_OUT    = 10'b00_0000_0100,
      CS_REQ_TIMEOUT  = 10'b00_0000_1000,
      CS_RESP_TIMEOUT = 10'b00_0001_0000,
      CS_DENIED       = 10'b00_0010_0000,
      CS_DISCONNECTED = 10'b00_0100_0000,
      CS_REQUESTING   = 10'b00_1000_0000,
      CS_RESPONDING   = 10'b01_0000_0000,
      CS_CONNECTED    = 10'b10_0000_0000
   } conn_state_type;

   typedef enum logic [2:0] {
      SEND_NONE       = 3'd0,
      SEND_REQUEST    = 3'd1,
      SEND_RESPONSE   = 3'd2,
      SEND_KEEPALIVE  = 3'd3,
      SEND_DISCONNECT = 3'd4
   } send_kind_type;

   typedef enum logic [1:0] {
      REQ_TICK       = 2'd0,
      REQ_PACKET     = 2'd1,
      REQ_CONNECT    = 2'd2,
      REQ_DISCONNECT = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      PK_DENIED      = 3'd0,
      PK_CHALLENGE   = 3'd1,
      PK_KEEPALIVE   = 3'd2,
      PK_PAYLOAD     = 3'd3,
      PK_PASSTHROUGH = 3'd4,
      PK_DISCONNECT  = 3'd5
   } packet_kind_type;

   typedef enum logic [1:0] {
      CSR_TIMEOUT      = 2'd0,
      CSR_LIFETIME     = 2'd1,
      CSR_SERVER_COUNT = 2'd2,
      CSR_RESEND       = 2'd3
   } csr_index_type;

   // One queue entry: everything the back end needs to emit an item's results.
   typedef struct packed {
      send_kind_type        send_kind;
      logic [COUNT_W-1:0]   count;
      logic [3:0]           state_now;
      logic [4:0]           server_slot;
      logic                 packet_taken;
      logic                 forward_data;
      logic [7:0]           client_slot;
      logic [7:0]           client_total;
      logic [63:0]          challenge;
   } rsp_desc_type;

   function automatic logic [3:0] state_code(conn_state_type s);
      logic [3:0] code;
      unique case (s)
         CS_EXPIRED:      code = ST_EXPIRED;
         CS_INVALID:      code = ST_INVALID;
         CS_TIMED_OUT:    code = ST_TIMED_OUT;
         CS_REQ_TIMEOUT:  code = ST_REQ_TIMEOUT;
         CS_RESP_TIMEOUT: code = ST_RESP_TIMEOUT;
         CS_DENIED:       code = ST_DENIED;
         CS_DISCONNECTED: code = ST_DISCONNECTED;
         CS_REQUESTING:   code = ST_REQUESTING;
         CS_RESPONDING:   code = ST_RESPONDING;
         CS_CONNECTED:    code = ST_CONNECTED;
         default:         code = ST_DISCONNECTED;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

### src/ucfsm_front.sv
// Front end: config registers, connection state and per-item decisions.
`timescale 1ns / 1ps
`default_nettype none
`include "udp_client_connection_fsm_top_macros.svh"
module ucfsm_front #(
   parameter int DISCONNECT_BURST = ucfsm_pkg::DISCONNECT_BURST_DEFAULT,
   parameter int MAX_SERVERS      = ucfsm_pkg::MAX_SERVERS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [1:0]             csr_index,
   input  wire logic [15:0]            csr_wr_data,
   input  wire logic                   accept,
   input  wire logic [1:0]             req_type,
   input  wire logic [31:0]            req_now_ms,
   input  wire logic [2:0]             req_packet_kind,
   input  wire logic                   req_from_server,
   input  wire logic [63:0]            req_challenge_sequence,
   input  wire logic [7:0]             req_slot_index,
   input  wire logic [7:0]             req_slot_total,
   input  wire logic                   req_token_valid,
   output logic                        push,
   output ucfsm_pkg::rsp_desc_type     desc
);
   import ucfsm_pkg::*;

   localparam int BURST_RES = (DISCONNECT_BURST < RES_CAP) ? DISCONNECT_BURST : RES_CAP;

   logic [CFG_MS_W-1:0] timeout_ms_ff, timeout_ms_in, lifetime_ms_ff, lifetime_ms_in;
   logic [5:0]          server_count_ff, server_count_in;
   logic [15:0]         resend_ms_ff, resend_ms_in;

   conn_state_type      state_ff, state_in, target_ff, target_in, drop_dest;
   logic [4:0]          index_ff, index_in;
   logic [31:0]         start_ff, start_in, now_ff, now_in, now_cur;
   logic signed [32:0]  send_ff, send_in, recv_ff, recv_in;
   logic                pending_ff, pending_in;
   logic [63:0]         chal_ff, chal_in, chal_out;
   logic [7:0]          slot_ff, slot_in, total_ff, total_in;

   logic signed [34:0]  t_wide, send_wide, recv_wide, start_wide;
   logic signed [34:0]  resend_wide, timeout_wide, lifetime_wide;
   logic                active, resend_due, silent, expired, more_servers;
   logic [5:0]          eff_count, next_index;
   logic                do_drop, do_burst, do_next, begin_att, drop_fires, burst_fired;
   logic                taken, fwd;
   send_kind_type       send_kind;
   req_kind_type        req_kind;
   packet_kind_type     pkt_kind;

   assign req_kind = req_kind_type'(req_type);
   assign pkt_kind = packet_kind_type'(req_packet_kind);
   assign now_cur  = (req_kind == REQ_TICK) ? req_now_ms : now_ff;

   // 35-bit signed compares cover every time difference without wrap
   assign t_wide        = {3'b000, now_cur};
   assign send_wide     = {{2{send_ff[32]}}, send_ff};
   assign recv_wide     = {{2{recv_ff[32]}}, recv_ff};
   assign start_wide    = {3'b000, start_ff};
   assign resend_wide   = {19'd0, resend_ms_ff};
   assign timeout_wide  = {9'd0, timeout_ms_ff};
   assign lifetime_wide = {9'd0, lifetime_ms_ff};

   assign active     = (state_ff == CS_REQUESTING) || (state_ff == CS_RESPONDING) ||
                       (state_ff == CS_CONNECTED);
   assign resend_due = (t_wide - send_wide) > resend_wide;
   assign silent     = (timeout_ms_ff != '0) && ((recv_wide + timeout_wide) < t_wide);
   assign expired    = (t_wide - start_wide) >= lifetime_wide;

   assign eff_count    = (server_count_ff > 6'(MAX_SERVERS)) ? 6'(MAX_SERVERS) : server_count_ff;
   assign next_index   = {1'b0, index_ff} + 6'd1;
   assign more_servers = next_index < eff_count;

   always_comb begin
      timeout_ms_in   = timeout_ms_ff;
      lifetime_ms_in  = lifetime_ms_ff;
      server_count_in = server_count_ff;
      resend_ms_in    = resend_ms_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIMEOUT:      timeout_ms_in  = CFG_MS_W'(32'(csr_wr_data) * 32'(MS_PER_S));
            CSR_LIFETIME:     lifetime_ms_in = CFG_MS_W'(32'(csr_wr_data) * 32'(MS_PER_S));
            CSR_SERVER_COUNT: server_count_in = csr_wr_data[5:0];
            CSR_RESEND:       resend_ms_in   = csr_wr_data;
            default:          resend_ms_in   = resend_ms_ff;
         endcase
      end
   end

   // decide what the item does
   always_comb begin
      do_drop   = 1'b0;
      do_burst  = 1'b0;
      do_next   = 1'b0;
      drop_dest = CS_DISCONNECTED;
      send_kind = SEND_NONE;
      chal_out  = '0;
      if (accept) begin
         unique case (req_kind)
            REQ_TICK: begin
               if (active && resend_due) begin
                  if (state_ff == CS_REQUESTING) begin
                     send_kind = SEND_REQUEST;
                  end else if (state_ff == CS_RESPONDING) begin
                     send_kind = SEND_RESPONSE;
                     chal_out  = chal_ff;
                  end else begin
                     send_kind = SEND_KEEPALIVE;
                  end
               end
               priority if (((state_ff == CS_REQUESTING) || (state_ff == CS_RESPONDING))
                            && expired) begin
                  do_drop   = 1'b1;
                  drop_dest = CS_EXPIRED;
               end else if (pending_ff) begin
                  if (more_servers) begin
                     do_next = 1'b1;
                  end else begin
                     do_drop   = 1'b1;
                     drop_dest = target_ff;
                  end
               end else if (silent) begin
                  if (state_ff == CS_CONNECTED) begin
                     do_drop   = 1'b1;
                     drop_dest = CS_TIMED_OUT;
                  end else if (more_servers && (state_ff == CS_REQUESTING ||
                                                state_ff == CS_RESPONDING)) begin
                     do_next = 1'b1;
                  end else if (state_ff == CS_REQUESTING) begin
                     do_drop   = 1'b1;
                     drop_dest = CS_REQ_TIMEOUT;
                  end else if (state_ff == CS_RESPONDING) begin
                     do_drop   = 1'b1;
                     drop_dest = CS_RESP_TIMEOUT;
                  end
               end else begin
               end
            end
            REQ_PACKET: begin
            end
            REQ_CONNECT, REQ_DISCONNECT: begin
               do_drop  = 1'b1;
               do_burst = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign drop_fires  = do_drop && active && (state_ff != drop_dest);
   assign burst_fired = drop_fires && do_burst;

   // apply the decisions to the state
   always_comb begin
      state_in   = state_ff;
      target_in  = target_ff;
      index_in   = index_ff;
      start_in   = start_ff;
      now_in     = now_ff;
      send_in    = send_ff;
      recv_in    = recv_ff;
      pending_in = pending_ff;
      chal_in    = chal_ff;
      slot_in    = slot_ff;
      total_in   = total_ff;
      taken      = 1'b0;
      fwd        = 1'b0;
      begin_att  = 1'b0;
      if (accept) begin
         if (req_kind == REQ_TICK) begin
            now_in = req_now_ms;
            if (send_kind != SEND_NONE) begin
               send_in = {1'b0, req_now_ms};
            end
         end
         if (req_kind == REQ_PACKET && req_from_server) begin
            unique case (pkt_kind)
               PK_DENIED: begin
                  if (state_ff == CS_REQUESTING || state_ff == CS_RESPONDING) begin
                     pending_in = 1'b1;
                     target_in  = CS_DENIED;
                     recv_in    = {1'b0, now_ff};
                     taken      = 1'b1;
                  end
               end
               PK_CHALLENGE: begin
                  if (state_ff == CS_REQUESTING) begin
                     chal_in  = req_challenge_sequence;
                     recv_in  = {1'b0, now_ff};
                     state_in = CS_RESPONDING;
                     taken    = 1'b1;
                  end
               end
               PK_KEEPALIVE: begin
                  if (state_ff == CS_CONNECTED) begin
                     recv_in = {1'b0, now_ff};
                     taken   = 1'b1;
                  end else if (state_ff == CS_RESPONDING) begin
                     recv_in  = {1'b0, now_ff};
                     slot_in  = req_slot_index;
                     total_in = req_slot_total;
                     state_in = CS_CONNECTED;
                     taken    = 1'b1;
                  end
               end
               PK_PAYLOAD, PK_PASSTHROUGH: begin
                  if (state_ff == CS_CONNECTED) begin
                     recv_in = {1'b0, now_ff};
                     taken   = 1'b1;
                     fwd     = 1'b1;
                  end
               end
               PK_DISCONNECT: begin
                  if (state_ff == CS_CONNECTED) begin
                     pending_in = 1'b1;
                     target_in  = CS_DISCONNECTED;
                     recv_in    = {1'b0, now_ff};
                     taken      = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         if (drop_fires) begin
            slot_in   = '0;
            total_in  = '0;
            index_in  = '0;
            state_in  = drop_dest;
            begin_att = 1'b1;
         end
         if (do_next) begin
            index_in  = next_index[4:0];
            state_in  = CS_REQUESTING;
            begin_att = 1'b1;
         end
         if (req_kind == REQ_CONNECT) begin
            if (!req_token_valid) begin
               state_in = CS_INVALID;
            end else begin
               index_in  = '0;
               state_in  = CS_REQUESTING;
               begin_att = 1'b1;
            end
         end
         if (begin_att) begin
            start_in   = now_cur;
            send_in    = $signed({1'b0, now_cur}) - 33'(ATTEMPT_BACKOFF_MS);
            recv_in    = {1'b0, now_cur};
            pending_in = 1'b0;
            target_in  = CS_DISCONNECTED;
            chal_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff   <= TIMEOUT_MS_RESET;
         lifetime_ms_ff  <= LIFETIME_MS_RESET;
         server_count_ff <= SERVER_COUNT_RESET;
         resend_ms_ff    <= RESEND_MS_RESET;
         state_ff        <= CS_DISCONNECTED;
         target_ff       <= CS_DISCONNECTED;
         index_ff        <= '0;
         start_ff        <= '0;
         now_ff          <= '0;
         send_ff         <= TIME_RESET_MS;
         recv_ff         <= TIME_RESET_MS;
         pending_ff      <= 1'b0;
         chal_ff         <= '0;
         slot_ff         <= '0;
         total_ff        <= '0;
      end else begin
         timeout_ms_ff   <= timeout_ms_in;
         lifetime_ms_ff  <= lifetime_ms_in;
         server_count_ff <= server_count_in;
         resend_ms_ff    <= resend_ms_in;
         state_ff        <= state_in;
         target_ff       <= target_in;
         index_ff        <= index_in;
         start_ff        <= start_in;
         now_ff          <= now_in;
         send_ff         <= send_in;
         recv_ff         <= recv_in;
         pending_ff      <= pending_in;
         chal_ff         <= chal_in;
         slot_ff         <= slot_in;
         total_ff        <= total_in;
      end
   end

   assign push = accept;

   always_comb begin
      desc.send_kind    = burst_fired ? SEND_DISCONNECT : send_kind;
      desc.count        = burst_fired ? COUNT_W'(BURST_RES) : COUNT_W'(1);
      desc.state_now    = state_code(state_in);
      desc.server_slot  = index_in;
      desc.packet_taken = taken;
      desc.forward_data = fwd;
      desc.client_slot  = slot_in;
      desc.client_total = total_in;
      desc.challenge    = chal_out;
   end

   // a pending disconnect only lives while a connection attempt is active
   `UCF_ASSERT(a_pending_active, clock, reset, pending_ff |-> active)

endmodule
`default_nettype wire

### src/ucfsm_queue.sv
// Short queue of result descriptors between front and back end.
`timescale 1ns / 1ps
`default_nettype none
`include "udp_client_connection_fsm_top_macros.svh"
module ucfsm_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ucfsm_pkg::rsp_desc_type push_desc,
   output logic                         full,
   output logic                         head_valid,
   output ucfsm_pkg::rsp_desc_type      head_desc,
   input  wire logic                    pop
);
   import ucfsm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_desc_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UCF_ASSERT(a_no_overflow, clock, reset, !(push && full))
   `UCF_ASSERT(a_no_underflow, clock, reset, !(pop && !head_valid))

endmodule
`default_nettype wire

### src/ucfsm_back.sv
// Back end: expands queued descriptors into result items on the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "udp_client_connection_fsm_top_macros.svh"
module ucfsm_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire ucfsm_pkg::rsp_desc_type head_desc,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [2:0]                   rsp_send_kind,
   output logic [3:0]                   rsp_state_now,
   output logic [4:0]                   rsp_server_slot,
   output logic                         rsp_packet_taken,
   output logic                         rsp_forward_data,
   output logic [7:0]                   rsp_client_slot,
   output logic [7:0]                   rsp_client_total,
   output logic [63:0]                  rsp_challenge_out,
   output logic                         rsp_last
);
   import ucfsm_pkg::*;

   rsp_desc_type        desc_ff, desc_in;
   logic [COUNT_W-1:0]  remain_ff, remain_in;
   logic                valid_ff, valid_in;
   logic                take, final_item;

   assign final_item = (remain_ff == COUNT_W'(1));
   assign take       = valid_ff && !rsp_stall;
   assign pop        = head_valid && (!valid_ff || (take && final_item));

   always_comb begin
      desc_in   = desc_ff;
      remain_in = remain_ff;
      valid_in  = valid_ff;
      if (pop) begin
         desc_in   = head_desc;
         remain_in = head_desc.count;
         valid_in  = 1'b1;
      end else if (take) begin
         remain_in = remain_ff - COUNT_W'(1);
         if (final_item) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_send_kind     = desc_ff.send_kind;
   assign rsp_state_now     = desc_ff.state_now;
   assign rsp_server_slot   = desc_ff.server_slot;
   assign rsp_packet_taken  = desc_ff.packet_taken;
   assign rsp_forward_data  = desc_ff.forward_data;
   assign rsp_client_slot   = desc_ff.client_slot;
   assign rsp_client_total  = desc_ff.client_total;
   assign rsp_challenge_out = desc_ff.challenge;
   assign rsp_last          = final_item;

   `UCF_ASSERT(a_valid_has_items, clock, reset, valid_ff |-> (remain_ff != '0))
   `UCF_ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> !valid_ff)

endmodule
`default_nettype wire

### src/udp_client_connection_fsm_top.sv
// An accepted item enters the descriptor queue, then the back end's output
// register, where rsp_stall can hold it. Throughput: one item per cycle while
// the queue is not full; results leave one per cycle unless stalled, so a
// disconnect burst of min(DISCONNECT_BURST, 11) results holds the output
// port while the two-entry descriptor queue absorbs following items. Reset:
// synchronous; state disconnected, registers default, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module udp_client_connection_fsm_top #(
   parameter int DISCONNECT_BURST = ucfsm_pkg::DISCONNECT_BURST_DEFAULT,
   parameter int MAX_SERVERS      = ucfsm_pkg::MAX_SERVERS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [2:0]  req_packet_kind,
   input  wire logic        req_from_server,
   input  wire logic [63:0] req_challenge_sequence,
   input  wire logic [7:0]  req_slot_index,
   input  wire logic [7:0]  req_slot_total,
   input  wire logic        req_token_valid,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_send_kind,
   output logic [3:0]       rsp_state_now,
   output logic [4:0]       rsp_server_slot,
   output logic             rsp_packet_taken,
   output logic             rsp_forward_data,
   output logic [7:0]       rsp_client_slot,
   output logic [7:0]       rsp_client_total,
   output logic [63:0]      rsp_challenge_out,
   output logic             rsp_last
);
   import ucfsm_pkg::*;

   rsp_desc_type push_desc, head_desc;
   logic         push, full, head_valid, pop, accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   ucfsm_front #(
      .DISCONNECT_BURST (DISCONNECT_BURST),
      .MAX_SERVERS      (MAX_SERVERS)
   ) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .accept                 (accept),
      .req_type               (req_type),
      .req_now_ms             (req_now_ms),
      .req_packet_kind        (req_packet_kind),
      .req_from_server        (req_from_server),
      .req_challenge_sequence (req_challenge_sequence),
      .req_slot_index         (req_slot_index),
      .req_slot_total         (req_slot_total),
      .req_token_valid        (req_token_valid),
      .push                   (push),
      .desc                   (push_desc)
   );

   ucfsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop)
   );

   ucfsm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_desc         (head_desc),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_send_kind     (rsp_send_kind),
      .rsp_state_now     (rsp_state_now),
      .rsp_server_slot   (rsp_server_slot),
      .rsp_packet_taken  (rsp_packet_taken),
      .rsp_forward_data  (rsp_forward_data),
      .rsp_client_slot   (rsp_client_slot),
      .rsp_client_total  (rsp_client_total),
      .rsp_challenge_out (rsp_challenge_out),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

### test/tb_udp_client_connection_fsm_top.sv
// Testbench for the client connection state machine: directed table, then guided random items.
`timescale 1ns / 1ps
module tb_udp_client_connection_fsm_top;
   import ucfsm_pkg::*;

   localparam int IDLE_LIMIT = 1000;

   // timeout_s, lifetime_s, server_count, resend_ms per random phase, in register order
   localparam logic [15:0] PHASE_CFG [5][4] = '{
      '{16'd2,     16'd5,     16'd3,     16'd50},
      '{16'd0,     16'd0,     16'd0,     16'd1},
      '{16'd65535, 16'd65535, 16'd63,    16'd65535},
      '{16'd1,     16'd2,     16'd32,    16'd200},
      '{16'd3,     16'd30,    16'hFFE8,  16'd7}
   };
   localparam int PHASE_ITEMS = 37;

   typedef struct packed {
      req_kind_type kind;
      logic [31:0]  now_ms;
      logic [2:0]   pkind;
      logic         from_srv;
      logic [63:0]  chal;
      logic [7:0]   slot;
      logic [7:0]   total;
      logic         token_ok;
   } req_item_type;

   typedef struct packed {
      send_kind_type kind;
      logic [3:0]    state;
      logic [4:0]    server;
      logic          taken;
      logic          fwd;
      logic [7:0]    slot;
      logic [7:0]    total;
      logic [63:0]   chal;
      logic          last;
   } rsp_type;

   typedef struct packed {
      req_item_type item;
      logic         typed;
      logic [3:0]   typed_state;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [15:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_type;
   logic [31:0] req_now_ms;
   logic [2:0] req_packet_kind;
   logic req_from_server;
   logic [63:0] req_challenge_sequence;
   logic [7:0] req_slot_index;
   logic [7:0] req_slot_total;
   logic req_token_valid;
   logic rsp_valid;
   logic rsp_stall;
   logic [2:0] rsp_send_kind;
   logic [3:0] rsp_state_now;
   logic [4:0] rsp_server_slot;
   logic rsp_packet_taken;
   logic rsp_forward_data;
   logic [7:0] rsp_client_slot;
   logic [7:0] rsp_client_total;
   logic [63:0] rsp_challenge_out;
   logic rsp_last;

   udp_client_connection_fsm_top dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_now_ms(req_now_ms),
      .req_packet_kind(req_packet_kind),
      .req_from_server(req_from_server),
      .req_challenge_sequence(req_challenge_sequence),
      .req_slot_index(req_slot_index),
      .req_slot_total(req_slot_total),
      .req_token_valid(req_token_valid),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_send_kind(rsp_send_kind),
      .rsp_state_now(rsp_state_now),
      .rsp_server_slot(rsp_server_slot),
      .rsp_packet_taken(rsp_packet_taken),
      .rsp_forward_data(rsp_forward_data),
      .rsp_client_slot(rsp_client_slot),
      .rsp_client_total(rsp_client_total),
      .rsp_challenge_out(rsp_challenge_out),
      .rsp_last(rsp_last)
   );

   always #4 clock = ~clock;

   // ---- predicted connection state ----
   logic [15:0] cfg_timeout_s;
   logic [15:0] cfg_lifetime_s;
   logic [5:0]  cfg_servers;
   logic [15:0] cfg_resend_ms;

   logic [3:0]  link_state;
   int          link_server;
   logic [31:0] link_start_ms;
   longint      link_last_tx;
   longint      link_last_rx;
   logic        link_pending;
   logic [3:0]  link_pending_dest;
   logic [63:0] link_challenge;
   logic [7:0]  link_slot;
   logic [7:0]  link_total;
   logic [31:0] link_now_ms;

   send_kind_type sent_kind_q[$];
   logic [63:0]   sent_chal_q[$];
   rsp_type       awaited_rsp[$];
   dir_row_type   dir_rows[$];

   logic [31:0] wall_ms;
   logic        calm;
   int          mismatch_total;
   int          idle_cycles;
   rsp_type     head_rsp;

   function automatic longint ms64(logic [31:0] v);
      return longint'({32'd0, v});
   endfunction

   function automatic void reset_link();
      cfg_timeout_s = 16'd0;
      cfg_lifetime_s = 16'd30;
      cfg_servers = 6'd1;
      cfg_resend_ms = 16'd100;
      link_state = ST_DISCONNECTED;
      link_server = 0;
      link_start_ms = '0;
      link_last_tx = TIME_RESET_MS;
      link_last_rx = TIME_RESET_MS;
      link_pending = 1'b0;
      link_pending_dest = ST_DISCONNECTED;
      link_challenge = '0;
      link_slot = '0;
      link_total = '0;
      link_now_ms = '0;
   endfunction

   function automatic void note_send(send_kind_type k, logic [63:0] ch);
      if (sent_kind_q.size() < RES_CAP) begin
         sent_kind_q.push_back(k);
         sent_chal_q.push_back(ch);
      end
   endfunction

   function automatic void restart_attempt();
      link_start_ms = link_now_ms;
      link_last_tx = ms64(link_now_ms) - ATTEMPT_BACKOFF_MS;
      link_last_rx = ms64(link_now_ms);
      link_pending = 1'b0;
      link_pending_dest = ST_DISCONNECTED;
      link_challenge = '0;
   endfunction

   function automatic void drop_link(logic [3:0] dest, logic burst);
      if (link_state <= ST_DISCONNECTED || link_state == dest)
         return;
      if (burst)
         repeat (DISCONNECT_BURST_DEFAULT) note_send(SEND_DISCONNECT, '0);
      link_slot = '0;
      link_total = '0;
      link_server = 0;
      link_state = dest;
      restart_attempt();
   endfunction

   function automatic logic try_next_server();
      int eff;
      eff = (cfg_servers > MAX_SERVERS_DEFAULT) ? MAX_SERVERS_DEFAULT : int'(cfg_servers);
      if (link_server + 1 >= eff)
         return 1'b0;
      link_server++;
      restart_attempt();
      link_state = ST_REQUESTING;
      return 1'b1;
   endfunction

   function automatic void evaluate_link();
      longint t;
      logic silent;
      t = ms64(link_now_ms);
      silent = cfg_timeout_s != 0 && link_last_rx + ms64(cfg_timeout_s) * MS_PER_S < t;
      // token lifetime bounds the handshake only
      if ((link_state == ST_REQUESTING || link_state == ST_RESPONDING) &&
          t - ms64(link_start_ms) >= ms64(cfg_lifetime_s) * MS_PER_S) begin
         drop_link(ST_EXPIRED, 1'b0);
         return;
      end
      if (link_pending) begin
         if (!try_next_server())
            drop_link(link_pending_dest, 1'b0);
         return;
      end
      if (!silent)
         return;
      if (link_state == ST_REQUESTING) begin
         if (!try_next_server())
            drop_link(ST_REQ_TIMEOUT, 1'b0);
      end else if (link_state == ST_RESPONDING) begin
         if (!try_next_server())
            drop_link(ST_RESP_TIMEOUT, 1'b0);
      end else if (link_state == ST_CONNECTED) begin
         drop_link(ST_TIMED_OUT, 1'b0);
      end
   endfunction

   function automatic void apply_tick(logic [31:0] now_v);
      longint t;
      link_now_ms = now_v;
      t = ms64(now_v);
      if (link_state >= ST_REQUESTING && link_state <= ST_CONNECTED &&
          t - link_last_tx > ms64(cfg_resend_ms)) begin
         if (link_state == ST_REQUESTING)
            note_send(SEND_REQUEST, '0);
         else if (link_state == ST_RESPONDING)
            note_send(SEND_RESPONSE, link_challenge);
         else
            note_send(SEND_KEEPALIVE, '0);
         link_last_tx = t;
      end
      evaluate_link();
   endfunction

   function automatic void apply_packet(req_item_type it, output logic taken,
                                        output logic fwd);
      longint t;
      t = ms64(link_now_ms);
      taken = 1'b0;
      fwd = 1'b0;
      if (!it.from_srv)
         return;
      case (it.pkind)
         PK_DENIED: if (link_state == ST_REQUESTING || link_state == ST_RESPONDING) begin
            link_pending = 1'b1;
            link_pending_dest = ST_DENIED;
            link_last_rx = t;
            taken = 1'b1;
         end
         PK_CHALLENGE: if (link_state == ST_REQUESTING) begin
            link_challenge = it.chal;
            link_last_rx = t;
            link_state = ST_RESPONDING;
            taken = 1'b1;
         end
         PK_KEEPALIVE: if (link_state == ST_CONNECTED) begin
            link_last_rx = t;
            taken = 1'b1;
         end else if (link_state == ST_RESPONDING) begin
            link_last_rx = t;
            link_slot = it.slot;
            link_total = it.total;
            link_state = ST_CONNECTED;
            taken = 1'b1;
         end
         PK_PAYLOAD, PK_PASSTHROUGH: if (link_state == ST_CONNECTED) begin
            link_last_rx = t;
            taken = 1'b1;
            fwd = 1'b1;
         end
         PK_DISCONNECT: if (link_state == ST_CONNECTED) begin
            link_pending = 1'b1;
            link_pending_dest = ST_DISCONNECTED;
            link_last_rx = t;
            taken = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // advances the predicted state by one item; queues its results when asked
   function automatic void advance_link(req_item_type it, logic keep);
      logic taken;
      logic fwd;
      rsp_type r;
      taken = 1'b0;
      fwd = 1'b0;
      sent_kind_q.delete();
      sent_chal_q.delete();
      case (it.kind)
         REQ_TICK: apply_tick(it.now_ms);
         REQ_PACKET: apply_packet(it, taken, fwd);
         REQ_CONNECT: begin
            drop_link(ST_DISCONNECTED, 1'b1);
            if (!it.token_ok) begin
               link_state = ST_INVALID;
            end else begin
               link_server = 0;
               restart_attempt();
               link_state = ST_REQUESTING;
            end
         end
         default: drop_link(ST_DISCONNECTED, 1'b1);
      endcase
      if (sent_kind_q.size() == 0)
         note_send(SEND_NONE, '0);
      if (keep) begin
         foreach (sent_kind_q[k]) begin
            r.kind = sent_kind_q[k];
            r.state = link_state;
            r.server = link_server[4:0];
            r.taken = taken;
            r.fwd = fwd;
            r.slot = link_slot;
            r.total = link_total;
            r.chal = (sent_kind_q[k] == SEND_RESPONSE) ? sent_chal_q[k] : 64'd0;
            r.last = (k == sent_kind_q.size() - 1);
            awaited_rsp.push_back(r);
         end
      end
   endfunction

   function automatic void add_row(req_kind_type k, logic [31:0] now_v, logic [2:0] pk,
                                   logic from_v, logic [63:0] ch, logic [7:0] sl,
                                   logic [7:0] tot, logic tok, logic typed, logic [3:0] st);
      dir_row_type row;
      row.item = '{kind: k, now_ms: now_v, pkind: pk, from_srv: from_v, chal: ch,
                   slot: sl, total: tot, token_ok: tok};
      row.typed = typed;
      row.typed_state = st;
      dir_rows.push_back(row);
   endfunction

   // random item steered by the predicted state, so handshakes get completed
   function automatic req_item_type pick_item();
      req_item_type it;
      int r;
      int s;
      it.kind = REQ_TICK;
      it.now_ms = $urandom;
      it.pkind = 3'($urandom_range(7));
      it.from_srv = ($urandom_range(9) != 0);
      it.chal = {$urandom, $urandom};
      it.slot = 8'($urandom_range(255));
      it.total = 8'($urandom_range(255));
      it.token_ok = 1'($urandom_range(1));
      r = $urandom_range(99);
      s = $urandom_range(99);
      if (r < 12) begin
         it.kind = req_kind_type'($urandom_range(3));
         it.from_srv = 1'($urandom_range(1));
      end else begin
         it.kind = REQ_PACKET;
         case (link_state)
            ST_REQUESTING:
               if (s < 45) it.kind = REQ_TICK;
               else if (s < 90) it.pkind = PK_CHALLENGE;
               else it.pkind = PK_DENIED;
            ST_RESPONDING:
               if (s < 40) it.kind = REQ_TICK;
               else if (s < 90) it.pkind = PK_KEEPALIVE;
               else it.pkind = PK_DENIED;
            ST_CONNECTED:
               if (s < 45) it.kind = REQ_TICK;
               else if (s < 55) it.pkind = PK_PAYLOAD;
               else if (s < 65) it.pkind = PK_PASSTHROUGH;
               else if (s < 80) it.pkind = PK_KEEPALIVE;
               else if (s < 87) it.pkind = PK_DISCONNECT;
               else if (s < 95) it.kind = REQ_DISCONNECT;
               else begin
                  it.kind = REQ_CONNECT;
                  it.token_ok = 1'b1;
               end
            default: begin
               it.kind = (s < 90) ? REQ_CONNECT : REQ_TICK;
               it.token_ok = (s < 80);
            end
         endcase
      end
      if (it.kind == REQ_TICK) begin
         if (r < 12) begin
            wall_ms = it.now_ms;
         end else begin
            s = $urandom_range(99);
            if (s < 70) wall_ms = wall_ms + $urandom_range(400, 20);
            else if (s < 85) wall_ms = wall_ms + $urandom_range(3000, 400);
            else if (s < 93) wall_ms = wall_ms + $urandom_range(80000, 4000);
            else if (s < 97) wall_ms = wall_ms - $urandom_range(2000, 1);  // clock steps back
            else wall_ms = $urandom;
            it.now_ms = wall_ms;
         end
      end
      return it;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_total++;
   endtask

   task automatic issue_item(req_item_type it, logic typed, logic [3:0] typed_state);
      rsp_type r;
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_now_ms <= it.now_ms;
      req_packet_kind <= it.pkind;
      req_from_server <= it.from_srv;
      req_challenge_sequence <= it.chal;
      req_slot_index <= it.slot;
      req_slot_total <= it.total;
      req_token_valid <= it.token_ok;
      // handshake sampled mid-cycle, the item goes in at the following edge
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      advance_link(it, !typed);
      if (typed) begin
         r = '0;
         r.kind = SEND_NONE;
         r.state = typed_state;
         r.last = 1'b1;
         awaited_rsp.push_back(r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic program_regs(int p);
      int i;
      for (i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wr_data <= PHASE_CFG[p][i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cfg_timeout_s = PHASE_CFG[p][CSR_TIMEOUT];
      cfg_lifetime_s = PHASE_CFG[p][CSR_LIFETIME];
      cfg_servers = PHASE_CFG[p][CSR_SERVER_COUNT][5:0];
      cfg_resend_ms = PHASE_CFG[p][CSR_RESEND];
   endtask

   // result checker; the payload is stable from mid-cycle up to the accepting edge
   always @(negedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("result with nothing awaited", 64'(rsp_send_kind), '0);
         end else begin
            head_rsp = awaited_rsp.pop_front();
            if (rsp_send_kind !== head_rsp.kind)
               report_mismatch("send_kind", 64'(rsp_send_kind), 64'(head_rsp.kind));
            if (rsp_state_now !== head_rsp.state)
               report_mismatch("state_now", 64'(rsp_state_now), 64'(head_rsp.state));
            if (rsp_server_slot !== head_rsp.server)
               report_mismatch("server_slot", 64'(rsp_server_slot), 64'(head_rsp.server));
            if (rsp_packet_taken !== head_rsp.taken)
               report_mismatch("packet_taken", 64'(rsp_packet_taken), 64'(head_rsp.taken));
            if (rsp_forward_data !== head_rsp.fwd)
               report_mismatch("forward_data", 64'(rsp_forward_data), 64'(head_rsp.fwd));
            if (rsp_client_slot !== head_rsp.slot)
               report_mismatch("client_slot", 64'(rsp_client_slot), 64'(head_rsp.slot));
            if (rsp_client_total !== head_rsp.total)
               report_mismatch("client_total", 64'(rsp_client_total), 64'(head_rsp.total));
            if (rsp_challenge_out !== head_rsp.chal)
               report_mismatch("challenge_out", rsp_challenge_out, head_rsp.chal);
            if (rsp_last !== head_rsp.last)
               report_mismatch("last", 64'(rsp_last), 64'(head_rsp.last));
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 12);
   end

   always @(negedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_udp_client_connection_fsm_top: errors");
         $finish;
      end
   end

   initial begin
      int p;
      reset <= 1'b1;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_TIMEOUT;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_type <= REQ_TICK;
      req_now_ms <= '0;
      req_packet_kind <= '0;
      req_from_server <= 1'b0;
      req_challenge_sequence <= '0;
      req_slot_index <= '0;
      req_slot_total <= '0;
      req_token_valid <= 1'b0;
      calm = 1'b0;
      mismatch_total = 0;
      idle_cycles = 0;
      wall_ms = '0;
      reset_link();

      // kind, now, packet kind, from server, challenge, slot, total, token, typed, state
      add_row(REQ_TICK, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b1, ST_DISCONNECTED);
      add_row(REQ_PACKET, 32'd0, 3'd7, 1'b1, '0, '0, '0, 1'b0, 1'b1, ST_DISCONNECTED);
      add_row(REQ_CONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b1, ST_INVALID);
      add_row(REQ_DISCONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b1, ST_INVALID);
      add_row(REQ_CONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b1, 1'b0, ST_REQUESTING);
      add_row(REQ_TICK, 32'd5, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_REQUESTING);
      add_row(REQ_PACKET, 32'd0, PK_CHALLENGE, 1'b1, '1, '0, '0, 1'b0, 1'b0, ST_RESPONDING);
      add_row(REQ_TICK, 32'd200, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_RESPONDING);
      add_row(REQ_PACKET, 32'd0, PK_KEEPALIVE, 1'b1, '0, 8'hFF, 8'hFF, 1'b0, 1'b0,
              ST_CONNECTED);
      add_row(REQ_PACKET, 32'd0, PK_PAYLOAD, 1'b1, '0, '0, '0, 1'b0, 1'b0, ST_CONNECTED);
      add_row(REQ_PACKET, 32'd0, PK_PASSTHROUGH, 1'b1, '0, '0, '0, 1'b0, 1'b0, ST_CONNECTED);
      add_row(REQ_TICK, 32'd400, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_CONNECTED);
      add_row(REQ_PACKET, 32'd0, PK_DENIED, 1'b1, '0, '0, '0, 1'b0, 1'b0, ST_CONNECTED);
      // disconnect of a live connection: full burst
      add_row(REQ_DISCONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b0,
              ST_DISCONNECTED);
      add_row(REQ_CONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b1, 1'b0, ST_REQUESTING);
      add_row(REQ_PACKET, 32'd0, PK_DENIED, 1'b1, '0, '0, '0, 1'b0, 1'b0, ST_REQUESTING);
      add_row(REQ_TICK, 32'd450, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_DENIED);
      add_row(REQ_CONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b1, 1'b0, ST_REQUESTING);
      add_row(REQ_PACKET, 32'd0, PK_CHALLENGE, 1'b1, 64'h8000_0000_0000_0001, '0, '0, 1'b0,
              1'b0, ST_RESPONDING);
      add_row(REQ_PACKET, 32'd0, PK_KEEPALIVE, 1'b1, '0, 8'h5A, 8'hA5, 1'b0, 1'b0,
              ST_CONNECTED);
      add_row(REQ_PACKET, 32'd0, PK_DISCONNECT, 1'b1, '0, '0, '0, 1'b0, 1'b0, ST_CONNECTED);
      // connect over a live connection bursts, then restarts the handshake
      add_row(REQ_CONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b1, 1'b0, ST_REQUESTING);
      add_row(REQ_TICK, 32'hFFFF_FFFF, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_EXPIRED);
      add_row(REQ_CONNECT, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b1, 1'b0, ST_REQUESTING);
      // time runs backwards: no resend, no expiry
      add_row(REQ_TICK, 32'd0, PK_DENIED, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_REQUESTING);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         issue_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_state);
      drain();

      for (p = 0; p < 5; p++) begin
         program_regs(p);
         calm = (p == 2);
         repeat (PHASE_ITEMS) issue_item(pick_item(), 1'b0, ST_DISCONNECTED);
         drain();
      end
      calm = 1'b0;

      repeat (8) @(posedge clock);
      if (mismatch_total == 0)
         $display("tb_udp_client_connection_fsm_top: clean");
      else
         $display("tb_udp_client_connection_fsm_top: errors");
      $finish;
   end

endmodule
